// ----- hdl/memory_map_bus_decoder_macros.svh -----
// Assertion macros for the memory map bus decoder.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef MEMORY_MAP_BUS_DECODER_MACROS_SVH
`define MEMORY_MAP_BUS_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MMBD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MMBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mmbd_pkg.sv -----
// Package of the memory map bus decoder: request, response and config types,
// operation, width, status and register codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mmbd_pkg;

  // Operation codes.
  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_APPEND = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Access width codes.
  localparam logic [1:0] W_BYTE   = 2'd0;
  localparam logic [1:0] W_HALF   = 2'd1;
  localparam logic [1:0] W_WORD   = 2'd2;
  localparam logic [1:0] W_UNUSED = 2'd3;

  // Status codes.
  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_UNALIGNED  = 3'd1;
  localparam logic [2:0] STAT_INVALID    = 3'd2;
  localparam logic [2:0] STAT_INPUT_END  = 3'd3;
  localparam logic [2:0] STAT_IMAGE_FULL = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_INSTR_BASE  = 2'd0;
  localparam logic [1:0] REG_DATA_BASE   = 2'd1;
  localparam logic [1:0] REG_INPUT_BASE  = 2'd2;
  localparam logic [1:0] REG_OUTPUT_BASE = 2'd3;

  // Configuration reset values.
  localparam logic [31:0] INSTR_BASE_RST  = 32'h1000_0000;
  localparam logic [31:0] DATA_BASE_RST   = 32'h2000_0000;
  localparam logic [31:0] INPUT_BASE_RST  = 32'h3000_0000;
  localparam logic [31:0] OUTPUT_BASE_RST = 32'h3000_0004;

  // Character ports are four bytes long; the character sits at offset three.
  localparam logic [31:0] PORT_BYTES       = 32'd4;
  localparam logic [31:0] PORT_CHAR_OFFSET = 32'd3;

  // Source of one read byte.
  localparam logic [1:0] SRC_ZERO  = 2'd0;
  localparam logic [1:0] SRC_IMAGE = 2'd1;
  localparam logic [1:0] SRC_DATA  = 2'd2;
  localparam logic [1:0] SRC_CHAR  = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] address;
    logic [1:0]  access_width;
    logic        sign_extend;
    logic [31:0] write_value;
    logic [7:0]  image_byte;
    logic [7:0]  input_char;
    logic        input_at_end;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [2:0]         status;
    logic               char_taken;
    logic               char_out_valid;
    logic [7:0]         char_out;
  } rsp_t;

  typedef struct packed {
    logic [31:0] instr_base;
    logic [31:0] data_base;
    logic [31:0] input_port_base;
    logic [31:0] output_port_base;
  } cfg_t;

  // Decoded request handed from the decode cycle to the assemble cycle.
  typedef struct packed {
    logic [3:0][1:0] src;
    logic [3:0][1:0] lane;
    logic [1:0]      width;
    logic            sign_extend;
    logic [7:0]      input_char;
    logic            assemble;
    rsp_t            base;
  } dec_t;

endpackage

`default_nettype wire

// ----- hdl/mmbd_store.sv -----
// Byte-lane synchronous memory: four lanes, each with its own row address.
// Read data is registered. No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mmbd_store #(
  parameter int unsigned DEPTH_BYTES = 4096,
  localparam int unsigned ROWS  = (DEPTH_BYTES + 3) / 4,
  localparam int unsigned ROW_W = $clog2(ROWS)
) (
  input  wire logic                       clk_i,
  input  wire logic [3:0]                 we_i,
  input  wire logic [3:0][ROW_W-1:0]      addr_i,
  input  wire logic [3:0][7:0]            wdata_i,
  output      logic [3:0][7:0]            rdata_o
);

  logic [7:0] lane_mem_q [4][ROWS];
  logic [3:0][7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < 4; b++) begin
      if (we_i[b]) begin
        lane_mem_q[b][addr_i[b]] <= wdata_i[b];
      end
      rdata_q[b] <= lane_mem_q[b][addr_i[b]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/mmbd_decode.sv -----
// Address decoder: region checks for every byte of an access, status and
// byte-lane memory commands. Depends on mmbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmbd_decode #(
  parameter int unsigned IMAGE_BYTES = 4096,
  parameter int unsigned DATA_BYTES  = 4096,
  localparam int unsigned IROW_W = $clog2((IMAGE_BYTES + 3) / 4),
  localparam int unsigned DROW_W = $clog2((DATA_BYTES + 3) / 4),
  localparam int unsigned LEN_W  = $clog2(IMAGE_BYTES + 1)
) (
  input  wire logic                   en_i,
  input  wire mmbd_pkg::req_t         req_i,
  input  wire mmbd_pkg::cfg_t         cfg_i,
  input  wire logic [LEN_W-1:0]       img_len_i,
  output      mmbd_pkg::dec_t         dec_o,
  output      logic                   img_len_inc_o,
  output      logic [3:0]             img_we_o,
  output      logic [3:0][IROW_W-1:0] img_addr_o,
  output      logic [3:0][7:0]        img_wdata_o,
  output      logic [3:0]             dat_we_o,
  output      logic [3:0][DROW_W-1:0] dat_addr_o,
  output      logic [3:0][7:0]        dat_wdata_o
);

  import mmbd_pkg::*;

  logic [3:0]       act, in_img, in_dat, in_pin, in_pout;
  logic [3:0][31:0] ioff, doff, poff, qoff;
  logic [3:0][7:0]  wbyte;
  logic [3:0][1:0]  isel, dsel;
  logic             unaligned, rd_bad, rd_port, wr_bad, wr_send;
  logic [7:0]       wr_char;

  // Per-byte region offsets; byte i sits at address + i with 32-bit wrap.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ioff[i]    = req_i.address - cfg_i.instr_base + 32'(i);
      doff[i]    = req_i.address - cfg_i.data_base + 32'(i);
      poff[i]    = req_i.address - cfg_i.input_port_base + 32'(i);
      qoff[i]    = req_i.address - cfg_i.output_port_base + 32'(i);
      in_img[i]  = ioff[i] < 32'(IMAGE_BYTES);
      in_dat[i]  = doff[i] < 32'(DATA_BYTES);
      in_pin[i]  = poff[i] < PORT_BYTES;
      in_pout[i] = qoff[i] < PORT_BYTES;
    end
    for (int b = 0; b < 4; b++) begin
      isel[b] = 2'(b) - ioff[0][1:0];
      dsel[b] = 2'(b) - doff[0][1:0];
    end
  end

  // Active bytes, alignment and big-endian split of the write data.
  always_comb begin
    wbyte = '0;
    case (req_i.access_width)
      W_BYTE: begin
        act       = 4'b0001;
        unaligned = 1'b0;
        wbyte[0]  = req_i.write_value[7:0];
      end
      W_HALF: begin
        act       = 4'b0011;
        unaligned = req_i.address[0];
        wbyte[0]  = req_i.write_value[15:8];
        wbyte[1]  = req_i.write_value[7:0];
      end
      default: begin
        act       = 4'b1111;
        unaligned = req_i.address[1:0] != 2'd0;
        wbyte[0]  = req_i.write_value[31:24];
        wbyte[1]  = req_i.write_value[23:16];
        wbyte[2]  = req_i.write_value[15:8];
        wbyte[3]  = req_i.write_value[7:0];
      end
    endcase
  end

  assign rd_bad  = |(act & ~(in_img | in_dat | in_pin));
  assign rd_port = |(act & ~in_img & ~in_dat & in_pin);
  assign wr_bad  = |(act & ~(in_dat | in_pout));
  assign wr_send = |(act & ~in_dat);

  always_comb begin
    wr_char = 8'd0;
    for (int i = 0; i < 4; i++) begin
      if (act[i] && !in_dat[i] && qoff[i] == PORT_CHAR_OFFSET) begin
        wr_char = wbyte[i];
      end
    end
  end

  always_comb begin
    dec_o             = '0;
    dec_o.width       = req_i.access_width;
    dec_o.sign_extend = req_i.sign_extend;
    dec_o.input_char  = req_i.input_char;
    img_len_inc_o     = 1'b0;
    img_we_o          = '0;
    dat_we_o          = '0;

    // Image regions win over data; port bytes other than offset three read zero.
    for (int i = 0; i < 4; i++) begin
      if (in_img[i]) begin
        dec_o.src[i]  = (ioff[i] < 32'(img_len_i)) ? SRC_IMAGE : SRC_ZERO;
        dec_o.lane[i] = ioff[i][1:0];
      end else if (in_dat[i]) begin
        dec_o.src[i]  = SRC_DATA;
        dec_o.lane[i] = doff[i][1:0];
      end else if (poff[i] == PORT_CHAR_OFFSET) begin
        dec_o.src[i]  = SRC_CHAR;
      end else begin
        dec_o.src[i]  = SRC_ZERO;
      end
    end

    for (int b = 0; b < 4; b++) begin
      img_addr_o[b]  = ioff[isel[b]][IROW_W+1:2];
      img_wdata_o[b] = req_i.image_byte;
      dat_addr_o[b]  = doff[dsel[b]][DROW_W+1:2];
      dat_wdata_o[b] = wbyte[dsel[b]];
    end

    if (req_i.op == OP_APPEND) begin
      if (img_len_i >= LEN_W'(IMAGE_BYTES)) begin
        dec_o.base.status = STAT_IMAGE_FULL;
      end else begin
        for (int b = 0; b < 4; b++) begin
          img_addr_o[b] = img_len_i[IROW_W+1:2];
        end
        img_we_o[img_len_i[1:0]] = en_i;
        img_len_inc_o            = en_i;
      end
    end else if (req_i.op == OP_UNUSED || req_i.access_width == W_UNUSED) begin
      dec_o.base.status = STAT_INVALID;
    end else if (unaligned) begin
      dec_o.base.status = STAT_UNALIGNED;
    end else if (req_i.op == OP_READ) begin
      if (rd_bad) begin
        dec_o.base.status = STAT_INVALID;
      end else if (rd_port && req_i.input_at_end) begin
        dec_o.base.status     = STAT_INPUT_END;
        dec_o.base.read_value = -32'sd1;
      end else begin
        dec_o.base.char_taken = rd_port;
        dec_o.assemble        = 1'b1;
      end
    end else begin
      if (wr_bad) begin
        dec_o.base.status = STAT_INVALID;
      end else begin
        dec_o.base.char_out_valid = wr_send;
        dec_o.base.char_out       = wr_char;
        for (int b = 0; b < 4; b++) begin
          dat_we_o[b] = en_i && act[dsel[b]] && in_dat[dsel[b]];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/memory_map_bus_decoder.sv -----
// Top level of the memory map bus decoder: sequencer, configuration registers,
// image and data stores, read assembly. Depends on mmbd_pkg, mmbd_decode, mmbd_store.
`timescale 1ns / 1ps
`default_nettype none

// A request is taken at a rising edge where start is high and busy is low. Its
// result appears on result_o with result_valid_o high for exactly one cycle,
// after the request has passed the decode and assemble states, and must be
// captured then: there is no back-pressure on the result side. Each request
// passes through a decode cycle that checks every byte and addresses the
// byte-lane memories, and an assemble cycle that consumes the registered
// read data. busy is low again during the assemble cycle, so the next
// request may be issued while a result is being formed or shown. After
// reset the data store is cleared row by row, four bytes per cycle, over
// all (DATA_BYTES + 3) / 4 rows; busy stays high until it is done.
// Configuration writes are accepted at any time but must only be issued
// while no request is in flight. The instruction image holds what was
// appended since reset; image bytes past the appended length read as zero.
module memory_map_bus_decoder #(
  parameter int unsigned IMAGE_BYTES = 4096,
  parameter int unsigned DATA_BYTES  = 4096
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output      logic            busy,
  input  wire mmbd_pkg::req_t  req_i,
  output      logic            result_valid_o,
  output      mmbd_pkg::rsp_t  result_o,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_idx_i,
  input  wire logic [31:0]     cfg_wdata_i
);

  import mmbd_pkg::*;

`include "memory_map_bus_decoder_macros.svh"

  localparam int unsigned DATA_ROWS = (DATA_BYTES + 3) / 4;
  localparam int unsigned IROW_W    = $clog2((IMAGE_BYTES + 3) / 4);
  localparam int unsigned DROW_W    = $clog2(DATA_ROWS);
  localparam int unsigned LEN_W     = $clog2(IMAGE_BYTES + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(IMAGE_BYTES);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_DECODE, ST_ASSEMBLE} state_e;

  state_e                 state_q;
  logic [DROW_W-1:0]      clr_q;
  logic                   result_valid_q;
  rsp_t                   result_q;
  cfg_t                   cfg_q;
  logic [LEN_W-1:0]       img_len_q;
  req_t                   req_q;
  dec_t                   dec_q;

  logic                   accept;
  logic                   clearing;
  dec_t                   dec;
  logic                   img_len_inc;
  logic [3:0]             img_we;
  logic [3:0][IROW_W-1:0] img_addr;
  logic [3:0][7:0]        img_wdata, img_rd;
  logic [3:0]             dec_dat_we, dat_we;
  logic [3:0][DROW_W-1:0] dec_dat_addr, dat_addr;
  logic [3:0][7:0]        dec_dat_wdata, dat_wdata, dat_rd;
  logic [3:0][7:0]        rbyte;
  logic [31:0]            value;
  rsp_t                   rsp_d;
  logic                   result_err;
  logic                   result_moved;

  // The next request may enter while the previous one is being assembled.
  assign busy     = state_q == ST_CLEAR || state_q == ST_DECODE;
  assign accept   = start && !busy;
  assign clearing = state_q == ST_CLEAR;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.instr_base       <= INSTR_BASE_RST;
      cfg_q.data_base        <= DATA_BASE_RST;
      cfg_q.input_port_base  <= INPUT_BASE_RST;
      cfg_q.output_port_base <= OUTPUT_BASE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INSTR_BASE:  cfg_q.instr_base       <= cfg_wdata_i;
        REG_DATA_BASE:   cfg_q.data_base        <= cfg_wdata_i;
        REG_INPUT_BASE:  cfg_q.input_port_base  <= cfg_wdata_i;
        REG_OUTPUT_BASE: cfg_q.output_port_base <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer with the registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_q          <= '0;
      result_valid_q <= 1'b0;
      result_q       <= '0;
    end else begin
      result_valid_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + DROW_W'(1);
          if (clr_q == DROW_W'(DATA_ROWS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          state_q <= ST_ASSEMBLE;
        end
        ST_ASSEMBLE: begin
          result_valid_q <= 1'b1;
          result_q       <= rsp_d;
          state_q        <= start ? ST_DECODE : ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Image length grows by one with every successful append.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_len_q <= '0;
    end else if (img_len_inc) begin
      img_len_q <= img_len_q + LEN_W'(1);
    end
  end

  // Request and decoded request carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (state_q == ST_DECODE) begin
      dec_q <= dec;
    end
  end

  // The decoder acts on the request held during the decode cycle. Stores are
  // written at the end of that cycle; the next request reads them no earlier
  // than its own decode cycle, after the assemble cycle, so no forwarding is required.
  mmbd_decode #(
    .IMAGE_BYTES (IMAGE_BYTES),
    .DATA_BYTES  (DATA_BYTES)
  ) u_decode (
    .en_i          (state_q == ST_DECODE),
    .req_i         (req_q),
    .cfg_i         (cfg_q),
    .img_len_i     (img_len_q),
    .dec_o         (dec),
    .img_len_inc_o (img_len_inc),
    .img_we_o      (img_we),
    .img_addr_o    (img_addr),
    .img_wdata_o   (img_wdata),
    .dat_we_o      (dec_dat_we),
    .dat_addr_o    (dec_dat_addr),
    .dat_wdata_o   (dec_dat_wdata)
  );

  mmbd_store #(
    .DEPTH_BYTES (IMAGE_BYTES)
  ) u_image_store (
    .clk_i   (clk_i),
    .we_i    (img_we),
    .addr_i  (img_addr),
    .wdata_i (img_wdata),
    .rdata_o (img_rd)
  );

  // The clearing pass zeroes one row in all four lanes per cycle.
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      dat_we[b]    = clearing ? 1'b1 : dec_dat_we[b];
      dat_addr[b]  = clearing ? clr_q : dec_dat_addr[b];
      dat_wdata[b] = clearing ? 8'd0 : dec_dat_wdata[b];
    end
  end

  mmbd_store #(
    .DEPTH_BYTES (DATA_BYTES)
  ) u_data_store (
    .clk_i   (clk_i),
    .we_i    (dat_we),
    .addr_i  (dat_addr),
    .wdata_i (dat_wdata),
    .rdata_o (dat_rd)
  );

  // Read assembly: byte 0 is the lowest address and the most significant byte.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      case (dec_q.src[i])
        SRC_IMAGE: rbyte[i] = img_rd[dec_q.lane[i]];
        SRC_DATA:  rbyte[i] = dat_rd[dec_q.lane[i]];
        SRC_CHAR:  rbyte[i] = dec_q.input_char;
        default:   rbyte[i] = 8'd0;
      endcase
    end
    case (dec_q.width)
      W_BYTE: value = {{24{dec_q.sign_extend & rbyte[0][7]}}, rbyte[0]};
      W_HALF: value = {{16{dec_q.sign_extend & rbyte[0][7]}}, rbyte[0], rbyte[1]};
      default: value = {rbyte[0], rbyte[1], rbyte[2], rbyte[3]};
    endcase
    rsp_d = dec_q.base;
    if (dec_q.assemble) begin
      rsp_d.read_value = value;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // A failed request must neither take nor send a character.
  assign result_err   = result_valid_o && result_o.status != STAT_OK;
  assign result_moved = result_o.char_taken || result_o.char_out_valid;

  `MMBD_ASSERT_NEXT(a_strobe_single, clk_i, rst_ni, result_valid_o, !result_valid_o, "strobe held")
  `MMBD_ASSERT_IMPL(a_result_follows, clk_i, rst_ni, accept, ##3 result_valid_o, "no result")
  `MMBD_ASSERT_IMPL(a_image_bound, clk_i, rst_ni, 1'b1, img_len_q <= LEN_MAX, "image overrun")
  `MMBD_ASSERT_IMPL(a_error_quiet, clk_i, rst_ni, result_err, !result_moved, "error moved a char")

endmodule

`default_nettype wire
